// ----- hdl/thl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// thl_pkg
// Shared widths, constants, types and helpers of the temperature history
// logger.
// ----------------------------------------------------------------------------
package thl_pkg;

  localparam int HISTORY_DEPTH  = 24;
  localparam int PTR_W          = $clog2(HISTORY_DEPTH);
  localparam int FILL_W         = $clog2(HISTORY_DEPTH + 1);

  localparam int RAW_W          = 12;
  localparam int TEMP_W         = 7;
  localparam int TEMP_MAX       = 60;
  localparam int BIG_LIMIT      = 30;
  localparam int LABEL_LIMIT    = BIG_LIMIT - 8;
  localparam int RECENT_N       = 4;

  localparam int MAG_W          = $clog2(TEMP_MAX * HISTORY_DEPTH + 1);
  localparam int SUM_W          = MAG_W + 1;
  localparam int WHOLE_W        = 6;
  localparam int TENTHS_W       = 4;
  localparam int T10_W          = WHOLE_W + 4;

  localparam int CNT_W          = 16;
  localparam int INTERVAL_RESET = 12 * 60;

  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 24;

  typedef logic signed [TEMP_W-1:0] temp_t;

  localparam temp_t BIG_POS = TEMP_W'(BIG_LIMIT);
  localparam temp_t BIG_NEG = TEMP_W'(-BIG_LIMIT);

  typedef struct packed {
    logic                    fill_pending;
    logic                    scale_two;
    logic                    bottom;
    temp_t                   newest;
    logic signed [SUM_W-1:0] sum;
  } hist_stat_t;

  typedef struct packed {
    logic                negative;
    logic [WHOLE_W-1:0]  whole;
    logic [TENTHS_W-1:0] tenths;
  } avg_res_t;

  function automatic logic is_big(temp_t v);
    return (v > BIG_POS) || (v < BIG_NEG);
  endfunction

endpackage
`default_nettype wire

// ----- hdl/thl_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// thl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module thl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/thl_hist.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// thl_hist
// History ring in RAM with running sum, count of large slots, the four
// newest slots in flops and the first-fill logic.
// ----------------------------------------------------------------------------
module thl_hist (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             load_i,
  input  wire logic signed [thl_pkg::RAW_W-1:0] raw_i,
  output      thl_pkg::hist_stat_t              stat_o
);

  localparam int DEG_W = thl_pkg::RAW_W - 4;
  localparam logic signed [DEG_W-1:0] DEG_HI = DEG_W'(thl_pkg::TEMP_MAX);
  localparam logic signed [DEG_W-1:0] DEG_LO = DEG_W'(-thl_pkg::TEMP_MAX);
  localparam thl_pkg::temp_t TEMP_HI = thl_pkg::TEMP_W'(thl_pkg::TEMP_MAX);
  localparam thl_pkg::temp_t TEMP_LO = thl_pkg::TEMP_W'(-thl_pkg::TEMP_MAX);
  localparam thl_pkg::temp_t LIMIT_ONE = thl_pkg::TEMP_W'(thl_pkg::LABEL_LIMIT);
  localparam thl_pkg::temp_t LIMIT_TWO = thl_pkg::TEMP_W'(2 * thl_pkg::LABEL_LIMIT + 1);
  localparam logic signed [thl_pkg::SUM_W-1:0] DEPTH_S =
    thl_pkg::SUM_W'(thl_pkg::HISTORY_DEPTH);

  logic                              round_up;
  logic signed [DEG_W-1:0]           deg_full;
  thl_pkg::temp_t                    deg_clamp;

  thl_pkg::temp_t                    deg_r;
  logic                              upd_r;
  logic [thl_pkg::PTR_W-1:0]         ptr_r, ptr_nxt;
  logic [thl_pkg::FILL_W-1:0]        since_r, since_nxt;
  thl_pkg::temp_t                    fill_val_r, fill_val_nxt;
  logic signed [thl_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [thl_pkg::FILL_W-1:0]        big_r, big_nxt;
  logic                              pending_r, pending_nxt;
  thl_pkg::temp_t                    tap_r   [thl_pkg::RECENT_N];
  thl_pkg::temp_t                    tap_nxt [thl_pkg::RECENT_N];

  logic [thl_pkg::TEMP_W-1:0]        ram_q;
  thl_pkg::temp_t                    oldest;
  logic                              do_fill;
  logic                              ram_we;
  thl_pkg::temp_t                    limit;
  logic                              bottom;

  // divide by 16 truncating toward zero, then clamp
  assign round_up = raw_i[thl_pkg::RAW_W-1] && (raw_i[3:0] != 4'd0);
  assign deg_full = $signed(raw_i[thl_pkg::RAW_W-1:4] + {{(DEG_W-1){1'b0}}, round_up});

  always_comb begin
    if (deg_full > DEG_HI) begin
      deg_clamp = TEMP_HI;
    end else if (deg_full < DEG_LO) begin
      deg_clamp = TEMP_LO;
    end else begin
      deg_clamp = deg_full[thl_pkg::TEMP_W-1:0];
    end
  end

  thl_ram #(
    .WIDTH (thl_pkg::TEMP_W),
    .DEPTH (thl_pkg::HISTORY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (deg_r),
    .re    (load_i),
    .raddr (ptr_r),
    .rdata (ram_q)
  );

  // slots not rewritten since the last fill still hold the fill value
  assign oldest  = (since_r == thl_pkg::FILL_W'(thl_pkg::HISTORY_DEPTH)) ?
                   $signed(ram_q) : fill_val_r;
  assign do_fill = pending_r && (deg_r != TEMP_HI) && (deg_r != TEMP_LO);
  assign ram_we  = upd_r && !do_fill;

  always_comb begin
    ptr_nxt      = ptr_r;
    since_nxt    = since_r;
    fill_val_nxt = fill_val_r;
    sum_nxt      = sum_r;
    big_nxt      = big_r;
    pending_nxt  = pending_r;
    for (int i = 0; i < thl_pkg::RECENT_N; i++) begin
      tap_nxt[i] = tap_r[i];
    end
    if (upd_r) begin
      if (do_fill) begin
        since_nxt    = '0;
        fill_val_nxt = deg_r;
        sum_nxt      = thl_pkg::SUM_W'(deg_r) * DEPTH_S;
        big_nxt      = thl_pkg::is_big(deg_r) ?
                       thl_pkg::FILL_W'(thl_pkg::HISTORY_DEPTH) : '0;
        pending_nxt  = 1'b0;
        for (int i = 0; i < thl_pkg::RECENT_N; i++) begin
          tap_nxt[i] = deg_r;
        end
      end else begin
        ptr_nxt   = (ptr_r == thl_pkg::PTR_W'(thl_pkg::HISTORY_DEPTH - 1)) ?
                    '0 : ptr_r + 1'b1;
        if (since_r != thl_pkg::FILL_W'(thl_pkg::HISTORY_DEPTH)) begin
          since_nxt = since_r + 1'b1;
        end
        sum_nxt   = sum_r + thl_pkg::SUM_W'(deg_r) - thl_pkg::SUM_W'(oldest);
        big_nxt   = big_r + thl_pkg::FILL_W'(thl_pkg::is_big(deg_r))
                    - thl_pkg::FILL_W'(thl_pkg::is_big(oldest));
        tap_nxt[0] = deg_r;
        for (int i = 1; i < thl_pkg::RECENT_N; i++) begin
          tap_nxt[i] = tap_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r      <= 1'b0;
      ptr_r      <= '0;
      since_r    <= '0;
      fill_val_r <= '0;
      sum_r      <= '0;
      big_r      <= '0;
      pending_r  <= 1'b1;
      for (int i = 0; i < thl_pkg::RECENT_N; i++) begin
        tap_r[i] <= '0;
      end
    end else begin
      upd_r      <= load_i;
      ptr_r      <= ptr_nxt;
      since_r    <= since_nxt;
      fill_val_r <= fill_val_nxt;
      sum_r      <= sum_nxt;
      big_r      <= big_nxt;
      pending_r  <= pending_nxt;
      for (int i = 0; i < thl_pkg::RECENT_N; i++) begin
        tap_r[i] <= tap_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      deg_r <= deg_clamp;
    end
  end

  // x / 2 > limit is the same as x > 2 * limit + 1
  assign limit = (big_r != '0) ? LIMIT_TWO : LIMIT_ONE;

  always_comb begin
    bottom = 1'b0;
    for (int i = 0; i < thl_pkg::RECENT_N; i++) begin
      if (tap_r[i] > limit) begin
        bottom = 1'b1;
      end
    end
  end

  assign stat_o.fill_pending = pending_r;
  assign stat_o.scale_two    = (big_r != '0);
  assign stat_o.bottom       = bottom;
  assign stat_o.newest       = tap_r[0];
  assign stat_o.sum          = sum_r;

endmodule
`default_nettype wire

// ----- hdl/thl_avg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// thl_avg
// History average as sign, whole part and tenths digit. Both quotients use
// exact reciprocal multiplies in one registered stage; the tenths digit is
// taken as floor(10 * mag / depth) - 10 * whole behind that register.
// ----------------------------------------------------------------------------
module thl_avg (
  input  wire logic                             clk,
  input  wire logic                             start_i,
  input  wire logic signed [thl_pkg::SUM_W-1:0] sum_i,
  output      thl_pkg::avg_res_t                res_o
);

  localparam int D_LOG   = $clog2(thl_pkg::HISTORY_DEPTH);
  localparam int K1      = thl_pkg::MAG_W + D_LOG;
  localparam int K2      = thl_pkg::MAG_W + 4 + D_LOG;
  localparam int RECIP1  = (2**K1 + thl_pkg::HISTORY_DEPTH - 1) / thl_pkg::HISTORY_DEPTH;
  localparam int RECIP10 =
    10 * ((2**K2 + thl_pkg::HISTORY_DEPTH - 1) / thl_pkg::HISTORY_DEPTH);
  localparam int P1_W    = thl_pkg::MAG_W + K1;
  localparam int P2_W    = thl_pkg::MAG_W + K2 + 4;

  logic signed [thl_pkg::SUM_W-1:0] abs_s;
  logic [thl_pkg::MAG_W-1:0]        mag;
  logic [P1_W-1:0]                  prod1;
  logic [P2_W-1:0]                  prod2;

  logic                             neg_r;
  logic [thl_pkg::WHOLE_W-1:0]      q_r;
  logic [thl_pkg::T10_W-1:0]        t10_r;
  logic [thl_pkg::T10_W-1:0]        q_x10;
  logic [thl_pkg::T10_W-1:0]        tenths_full;

  assign abs_s = sum_i[thl_pkg::SUM_W-1] ? -sum_i : sum_i;
  assign mag   = abs_s[thl_pkg::MAG_W-1:0];
  assign prod1 = P1_W'(mag) * P1_W'(RECIP1);
  assign prod2 = P2_W'(mag) * P2_W'(RECIP10);

  always_ff @(posedge clk) begin
    if (start_i) begin
      neg_r <= sum_i[thl_pkg::SUM_W-1];
      q_r   <= prod1[K1 +: thl_pkg::WHOLE_W];
      t10_r <= prod2[K2 +: thl_pkg::T10_W];
    end
  end

  assign q_x10       = (thl_pkg::T10_W'(q_r) << 3) + (thl_pkg::T10_W'(q_r) << 1);
  assign tenths_full = t10_r - q_x10;

  assign res_o.negative = neg_r;
  assign res_o.whole    = q_r;
  assign res_o.tenths   = tenths_full[thl_pkg::TENTHS_W-1:0];

endmodule
`default_nettype wire

// ----- hdl/temperature_history_logger.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// temperature_history_logger
// A reading passes, in order: accept with history RAM read, read-modify-write
// of the ring and running sums, reciprocal multiply, output register load.
// The input is not ready for the next reading until that output register load,
// which waits while the output register still holds an undrained result.
// Reset (synchronous, rst_n low) empties the history to zero, arms the first
// fill and restores sample_interval to 720; no clearing pass is needed.
// ----------------------------------------------------------------------------
module temperature_history_logger (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // [11:0] raw_temperature
  input  wire logic [thl_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // [0] stored, [7:1] newest_value, [8] double_scale, [9] average_negative,
  // [15:10] average_whole, [19:16] average_tenths, [20] label_at_bottom
  output      logic [thl_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic [thl_pkg::CNT_W-1:0]          cfg_data,
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_AVG  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  typedef struct packed {
    logic                         label;
    logic [thl_pkg::TENTHS_W-1:0] tenths;
    logic [thl_pkg::WHOLE_W-1:0]  whole;
    logic                         negative;
    logic                         scale;
    thl_pkg::temp_t               newest;
    logic                         stored;
  } out_item_t;

  localparam int OUT_USED_W = $bits(out_item_t);

  logic [1:0]                state_r, state_nxt;
  logic [thl_pkg::CNT_W-1:0] interval_r;
  logic [thl_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [thl_pkg::CNT_W-1:0] count_inc;
  logic                      stored_r;
  logic                      in_acc;
  logic                      do_store;
  logic                      out_load;
  logic                      out_tvalid_r;
  out_item_t                 out_item_r;

  thl_pkg::hist_stat_t       hist_stat;
  thl_pkg::avg_res_t         avg_res;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign count_inc = count_r + 1'b1;
  assign do_store  = (count_inc >= interval_r) || hist_stat.fill_pending;
  assign count_nxt = do_store ? '0 : count_inc;

  thl_hist u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .load_i (in_acc && do_store),
    .raw_i  ($signed(in_tdata[thl_pkg::RAW_W-1:0])),
    .stat_o (hist_stat)
  );

  thl_avg u_avg (
    .clk     (clk),
    .start_i (state_r == ST_AVG),
    .sum_i   (hist_stat.sum),
    .res_o   (avg_res)
  );

  assign out_load = (state_r == ST_FIN) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD:  state_nxt = ST_AVG;
      ST_AVG:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      interval_r   <= thl_pkg::CNT_W'(thl_pkg::INTERVAL_RESET);
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        interval_r <= cfg_data;
      end
      if (in_acc) begin
        count_r <= count_nxt;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stored_r <= do_store;
    end
    if (out_load) begin
      out_item_r.label    <= hist_stat.bottom;
      out_item_r.tenths   <= avg_res.tenths;
      out_item_r.whole    <= avg_res.whole;
      out_item_r.negative <= avg_res.negative;
      out_item_r.scale    <= hist_stat.scale_two;
      out_item_r.newest   <= hist_stat.newest;
      out_item_r.stored   <= stored_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(thl_pkg::OUT_TDATA_W - OUT_USED_W){1'b0}}, out_item_r};

  // one reading in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted while a reading is in flight");

  a_first_fill_stores: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && hist_stat.fill_pending) |=> stored_r)
    else $error("reading not stored during first fill");

  a_average_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> ((out_item_r.tenths <= thl_pkg::TENTHS_W'(9)) &&
                      (out_item_r.whole <= thl_pkg::WHOLE_W'(thl_pkg::TEMP_MAX))))
    else $error("average digits out of range");

  a_scale_covers_newest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && thl_pkg::is_big(out_item_r.newest)) |-> out_item_r.scale)
    else $error("large newest slot without double scale");

endmodule
`default_nettype wire
